@@ rtl/task_queue_with_sorted_insert_macros.svh @@
// Assertion macros shared by the task queue RTL.
// Relies on signals named clock and reset in the including module.
`ifndef TASK_QUEUE_WITH_SORTED_INSERT_MACROS_SVH
`define TASK_QUEUE_WITH_SORTED_INSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define TQSI_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("task queue check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define TQSI_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("task queue check failed");

`endif

@@ rtl/tqsi_pkg.sv @@
// Package for the task queue: id width, command codes, cell control struct.
// No dependencies.
`timescale 1ns / 1ps
package tqsi_pkg;
   localparam int TASK_BITS = 4;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;
   localparam logic [1:0] CMD_PEEK   = 2'd3;

   typedef struct packed {
      logic push;    // accepted push with room left
      logic sorted;  // push is a key-ordered insert
      logic pop;     // pop with queue not empty
   } tqsi_ctrl_type;
endpackage

@@ rtl/tqsi_cell.sv @@
// One slot of the queue: holds an id and key, shifts towards head or tail.
// Depends on tqsi_pkg.
`timescale 1ns / 1ps
module tqsi_cell #(
   parameter int KEY_BITS = 32,
   parameter bit IS_HEAD  = 1'b0
) (
   input  logic                          clock,
   input  tqsi_pkg::tqsi_ctrl_type       ctrl,
   input  logic                          occupied,
   input  logic [tqsi_pkg::TASK_BITS-1:0] new_task,
   input  logic [KEY_BITS-1:0]           new_key,
   input  logic [tqsi_pkg::TASK_BITS-1:0] left_task,
   input  logic [KEY_BITS-1:0]           left_key,
   input  logic [tqsi_pkg::TASK_BITS-1:0] right_task,
   input  logic [KEY_BITS-1:0]           right_key,
   input  logic                          found_in,
   output logic                          found_out,
   output logic [tqsi_pkg::TASK_BITS-1:0] task_out,
   output logic [KEY_BITS-1:0]           key_out
);
   import tqsi_pkg::*;

   logic [TASK_BITS-1:0] task_ff, task_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic                 ge;
   logic                 hit;

   // head slot only yields to a strictly smaller key
   assign ge  = IS_HEAD ? (key_ff > new_key) : (key_ff >= new_key);
   assign hit = !occupied || (ctrl.sorted && ge);
   assign found_out = found_in || hit;

   always_comb begin
      task_in = task_ff;
      key_in  = key_ff;
      if (ctrl.pop) begin
         task_in = right_task;
         key_in  = right_key;
      end else if (ctrl.push) begin
         if (found_in) begin
            task_in = left_task;
            key_in  = left_key;
         end else if (hit) begin
            task_in = new_task;
            key_in  = new_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      task_ff <= task_in;
      key_ff  <= key_in;
   end

   assign task_out = task_ff;
   assign key_out  = key_ff;
endmodule

@@ rtl/task_queue_with_sorted_insert.sv @@
// Top level of the sorted task queue: command decode, fill count, cell row.
// Depends on tqsi_pkg, tqsi_cell and task_queue_with_sorted_insert_macros.svh.
//
//   channel   ports                      handshake
//   command   start, busy, req_*         beat taken when start && !busy
//   result    rsp_strobe, rsp_*          one beat, one cycle, no back-pressure
//
// One command per cycle; busy is always low. The result appears the cycle after
// the command beat. The insert position is resolved during the beat cycle by a found
// signal rippling through the cells; cells from that slot on shift at the beat edge.
// Reset empties the queue at once; slot contents are left as they are.
`timescale 1ns / 1ps
module task_queue_with_sorted_insert #(
   parameter int MAX_TASKS = 16,
   parameter int KEY_BITS  = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_command,
   input  logic [tqsi_pkg::TASK_BITS-1:0]       req_task_id,
   input  logic [KEY_BITS-1:0]                  req_sort_key,
   output logic                                 rsp_strobe,
   output logic                                 rsp_head_valid,
   output logic [tqsi_pkg::TASK_BITS-1:0]       rsp_head_task,
   output logic [KEY_BITS-1:0]                  rsp_head_key,
   output logic [$clog2(MAX_TASKS+1)-1:0]       rsp_entry_count,
   output logic                                 rsp_status
);
   import tqsi_pkg::*;

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   logic                 accept;
   logic                 is_push;
   logic                 is_read;
   logic                 full;
   logic                 empty;
   tqsi_ctrl_type        ctrl;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 strobe_ff;
   logic                 hvalid_ff, hvalid_in;
   logic [TASK_BITS-1:0] htask_ff, htask_in;
   logic [KEY_BITS-1:0]  hkey_ff, hkey_in;
   logic                 status_ff, status_in;

   logic [TASK_BITS-1:0] cell_task [MAX_TASKS];
   logic [KEY_BITS-1:0]  cell_key  [MAX_TASKS];
   logic                 found     [MAX_TASKS+1];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign full    = (count_ff == CNT_W'(MAX_TASKS));
   assign empty   = (count_ff == '0);
   assign is_push = (req_command == CMD_APPEND) || (req_command == CMD_INSERT);
   assign is_read = (req_command == CMD_POP) || (req_command == CMD_PEEK);

   assign ctrl.push   = accept && is_push && !full;
   assign ctrl.sorted = (req_command == CMD_INSERT);
   assign ctrl.pop    = accept && (req_command == CMD_POP) && !empty;

   assign found[0] = 1'b0;

   genvar i;
   generate
      for (i = 0; i < MAX_TASKS; i++) begin : g_cell
         logic                 occ;
         logic [TASK_BITS-1:0] l_task, r_task;
         logic [KEY_BITS-1:0]  l_key, r_key;

         assign occ = (count_ff > CNT_W'(i));

         if (i == 0) begin : g_left_edge
            assign l_task = cell_task[i];
            assign l_key  = cell_key[i];
         end else begin : g_left
            assign l_task = cell_task[i-1];
            assign l_key  = cell_key[i-1];
         end

         if (i == MAX_TASKS - 1) begin : g_right_edge
            assign r_task = cell_task[i];
            assign r_key  = cell_key[i];
         end else begin : g_right
            assign r_task = cell_task[i+1];
            assign r_key  = cell_key[i+1];
         end

         tqsi_cell #(
            .KEY_BITS (KEY_BITS),
            .IS_HEAD  (i == 0)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (occ),
            .new_task   (req_task_id),
            .new_key    (req_sort_key),
            .left_task  (l_task),
            .left_key   (l_key),
            .right_task (r_task),
            .right_key  (r_key),
            .found_in   (found[i]),
            .found_out  (found[i+1]),
            .task_out   (cell_task[i]),
            .key_out    (cell_key[i])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      hvalid_in = 1'b0;
      htask_in  = '0;
      hkey_in   = '0;
      status_in = 1'b0;
      if (ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept && is_push && full) begin
         status_in = 1'b1;
      end
      if (accept && is_read && !empty) begin
         hvalid_in = 1'b1;
         htask_in  = cell_task[0];
         hkey_in   = cell_key[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hvalid_ff <= hvalid_in;
         htask_ff  <= htask_in;
         hkey_ff   <= hkey_in;
         status_ff <= status_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_head_valid  = hvalid_ff;
   assign rsp_head_task   = htask_ff;
   assign rsp_head_key    = hkey_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_status      = status_ff;

`include "task_queue_with_sorted_insert_macros.svh"

   `TQSI_ASSERT(a_count_bound, count_ff <= CNT_W'(MAX_TASKS))
   `TQSI_ASSERT_NEXT(a_full_drop, accept && is_push && full,
                     rsp_status && count_ff == CNT_W'(MAX_TASKS))
   `TQSI_ASSERT_NEXT(a_pop_dec, ctrl.pop, count_ff == $past(count_ff) - CNT_W'(1))
   `TQSI_ASSERT(a_valid_needs_count, !(rsp_strobe && rsp_head_valid) || !empty ||
                $past(req_command) == CMD_POP)
endmodule
